/* rtl/flipbook_frame_sequencer_core_assert.svh */
// Assertion macros for the flipbook frame sequencer, included by fbseq_seq
`ifndef FLIPBOOK_FRAME_SEQUENCER_CORE_ASSERT_SVH
`define FLIPBOOK_FRAME_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define FBSEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbseq assertion failed");

// Next-cycle implication, disabled during reset
`define FBSEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbseq assertion failed");

`endif

/* rtl/fbseq_pkg.sv */
// Package with the types, constants and codes of the flipbook frame sequencer
`default_nettype none
package fbseq_pkg;

   // sequence limits and field widths
   localparam int MAX_FRAMES = 256;
   localparam int CNT_W      = 9;
   localparam int POS_W      = 8;
   localparam int TIME_W     = 24;
   localparam int ACC_W      = 32;
   localparam int STEP_W     = CNT_W + 2;
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;

   // play style codes
   localparam logic [1:0] STYLE_LOOP     = 2'd0;
   localparam logic [1:0] STYLE_ONCE     = 2'd1;
   localparam logic [1:0] STYLE_PINGPONG = 2'd2;

   // transaction codes
   localparam logic OP_BEGIN   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // register indexes (word address)
   localparam logic [1:0] REG_STYLE  = 2'd0;
   localparam logic [1:0] REG_INVERT = 2'd1;
   localparam logic [1:0] REG_COUNT  = 2'd2;
   localparam logic [1:0] REG_PERIOD = 2'd3;

   typedef struct packed {
      logic [1:0]        style;
      logic              invert;
      logic [CNT_W-1:0]  count;
      logic [TIME_W-1:0] period;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             bounce;
   } step_in_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             bounce;
      logic             stop;
   } step_out_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_ADD,
      SEQ_STEP,
      SEQ_DONE
   } seq_state_type;

endpackage
`default_nettype wire

/* rtl/fbseq_csr.sv */
// Configuration register file with its APB-style access port
`default_nettype none
module fbseq_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [fbseq_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [fbseq_pkg::DATA_W-1:0]  pwdata,
   output logic      [fbseq_pkg::DATA_W-1:0]  prdata,
   output logic                               pready,
   output fbseq_pkg::cfg_type                 cfg
);

   fbseq_pkg::cfg_type cfg_ff, cfg_in;
   logic               wr_en;
   logic [1:0]         reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];
   assign cfg     = cfg_ff;

   // decode the write transaction
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            fbseq_pkg::REG_STYLE:  cfg_in.style  = pwdata[1:0];
            fbseq_pkg::REG_INVERT: cfg_in.invert = pwdata[0];
            fbseq_pkg::REG_COUNT:  cfg_in.count  = pwdata[fbseq_pkg::CNT_W-1:0];
            fbseq_pkg::REG_PERIOD: cfg_in.period = pwdata[fbseq_pkg::TIME_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (reg_sel)
         fbseq_pkg::REG_STYLE:  prdata = fbseq_pkg::DATA_W'(cfg_ff.style);
         fbseq_pkg::REG_INVERT: prdata = fbseq_pkg::DATA_W'(cfg_ff.invert);
         fbseq_pkg::REG_COUNT:  prdata = fbseq_pkg::DATA_W'(cfg_ff.count);
         fbseq_pkg::REG_PERIOD: prdata = fbseq_pkg::DATA_W'(cfg_ff.period);
         default:               prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/fbseq_step.sv */
// Single frame step: next index, bounce state and stop flag for the configured play style
`default_nettype none
module fbseq_step (
   input  wire fbseq_pkg::cfg_type          cfg,
   input  wire logic [fbseq_pkg::CNT_W-1:0] eff_n,
   input  wire fbseq_pkg::step_in_type      cur,
   output fbseq_pkg::step_out_type          nxt
);

   localparam int SW = fbseq_pkg::STEP_W;

   logic signed [SW-1:0] idx;
   logic signed [SW-1:0] n_s;
   logic signed [SW-1:0] top;
   logic signed [SW-1:0] fwd;
   logic signed [SW-1:0] dir;
   logic signed [SW-1:0] last;
   logic signed [SW-1:0] t;
   logic                 bnc;
   logic                 stop;

   always_comb begin
      idx  = signed'(SW'(cur.pos));
      n_s  = signed'(SW'(eff_n));
      top  = n_s - SW'(1);
      fwd  = cfg.invert ? '1 : SW'(1);
      dir  = cur.bounce ? -fwd : fwd;
      last = cfg.invert ? '0 : top;
      t    = idx;
      bnc  = cur.bounce;
      stop = 1'b0;

      // move one frame according to the style
      case (cfg.style)
         fbseq_pkg::STYLE_LOOP: begin
            t = idx + fwd;
            if (t < 0) begin
               t = top;
            end else if (t >= n_s) begin
               t = '0;
            end
         end
         fbseq_pkg::STYLE_ONCE: begin
            if (idx != last) begin
               t = idx + fwd;
               if (t < 0) begin
                  t = '0;
               end else if (t >= n_s) begin
                  t = top;
               end
            end
            stop = (t == last);
         end
         fbseq_pkg::STYLE_PINGPONG: begin
            t = idx + dir;
            if (t < 0 || t >= n_s) begin
               bnc = ~cur.bounce;
               t   = idx - dir;
               if (t < 0) begin
                  t = '0;
               end else if (t >= n_s) begin
                  t = top;
               end
            end
         end
         default: t = idx;
      endcase

      // clamp into the frame range
      if (t > top) begin
         t = top;
      end
      if (t < 0) begin
         t = '0;
      end

      nxt.pos    = t[fbseq_pkg::POS_W-1:0];
      nxt.bounce = bnc;
      nxt.stop   = stop;
   end

endmodule
`default_nettype wire

/* rtl/fbseq_seq.sv */
// Sequencer with the shared add/subtract unit, play state and result register
`default_nettype none
module fbseq_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fbseq_pkg::cfg_type            cfg,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_op,
   input  wire logic [fbseq_pkg::TIME_W-1:0]  req_elapsed,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [fbseq_pkg::POS_W-1:0]   rsp_frame_index,
   output logic                               rsp_playing,
   output logic                               rsp_reversing,
   output logic      [fbseq_pkg::CNT_W-1:0]   rsp_steps_taken
);

   localparam int AW = fbseq_pkg::ACC_W;
   localparam int CW = fbseq_pkg::CNT_W;
   localparam int PW = fbseq_pkg::POS_W;

   fbseq_pkg::seq_state_type state_ff, state_in;

   logic [PW-1:0]                  pos_ff, pos_in;
   logic [AW-1:0]                  accum_ff, accum_in;
   logic                           bounce_ff, bounce_in;
   logic                           run_ff, run_in;
   logic [CW-1:0]                  steps_ff, steps_in;
   logic [fbseq_pkg::TIME_W-1:0]   elapsed_ff, elapsed_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]                  rsp_pos_ff, rsp_pos_in;
   logic                           rsp_run_ff, rsp_run_in;
   logic                           rsp_bounce_ff, rsp_bounce_in;
   logic [CW-1:0]                  rsp_steps_ff, rsp_steps_in;

   logic [CW-1:0]                  eff_n;
   logic [CW-1:0]                  cap;
   logic [CW:0]                    steps_inc;
   logic                           adv_ok;
   logic                           accept;
   logic                           load_rsp;

   logic [AW-1:0]                  alu_b;
   logic                           alu_cin;
   logic [AW:0]                    alu_sum;
   logic                           alu_carry;

   fbseq_pkg::step_in_type         step_cur;
   fbseq_pkg::step_out_type        step_nxt;

   // effective frame count and step cap
   assign eff_n = (cfg.count > CW'(fbseq_pkg::MAX_FRAMES)) ?
                  CW'(fbseq_pkg::MAX_FRAMES) : cfg.count;
   assign cap       = eff_n + CW'(1);
   assign steps_inc = {1'b0, steps_ff} + (CW+1)'(1);
   assign adv_ok    = run_ff && (eff_n > CW'(1)) && (cfg.period != '0);

   assign req_stall = (state_ff != fbseq_pkg::SEQ_IDLE);
   assign accept    = req_valid && !req_stall;
   assign load_rsp  = (state_ff == fbseq_pkg::SEQ_DONE) && (!rsp_valid_ff || !rsp_stall);

   // shared adder: accumulate elapsed time, or subtract one period and compare
   assign alu_cin   = (state_ff == fbseq_pkg::SEQ_STEP);
   assign alu_b     = alu_cin ? ~AW'(cfg.period) : AW'(elapsed_ff);
   assign alu_sum   = {1'b0, accum_ff} + {1'b0, alu_b} + (AW+1)'(alu_cin);
   assign alu_carry = alu_sum[AW];

   assign step_cur.pos    = pos_ff;
   assign step_cur.bounce = bounce_ff;

   fbseq_step u_step (
      .cfg   (cfg),
      .eff_n (eff_n),
      .cur   (step_cur),
      .nxt   (step_nxt)
   );

   // next state and datapath
   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      accum_in   = accum_ff;
      bounce_in  = bounce_ff;
      run_in     = run_ff;
      steps_in   = steps_ff;
      elapsed_in = elapsed_ff;

      case (state_ff)
         fbseq_pkg::SEQ_IDLE: begin
            if (accept) begin
               steps_in   = '0;
               elapsed_in = req_elapsed;
               if (req_op == fbseq_pkg::OP_BEGIN) begin
                  pos_in    = (cfg.invert && eff_n != '0) ? PW'(eff_n - CW'(1)) : '0;
                  accum_in  = '0;
                  bounce_in = 1'b0;
                  run_in    = 1'b1;
                  state_in  = fbseq_pkg::SEQ_DONE;
               end else if (adv_ok) begin
                  state_in = fbseq_pkg::SEQ_ADD;
               end else begin
                  state_in = fbseq_pkg::SEQ_DONE;
               end
            end
         end
         fbseq_pkg::SEQ_ADD: begin
            // saturate on carry out
            accum_in = alu_carry ? '1 : alu_sum[AW-1:0];
            state_in = fbseq_pkg::SEQ_STEP;
         end
         fbseq_pkg::SEQ_STEP: begin
            if (alu_carry && steps_ff < cap) begin
               accum_in  = alu_sum[AW-1:0];
               steps_in  = steps_inc[CW-1:0];
               pos_in    = step_nxt.pos;
               bounce_in = step_nxt.bounce;
               if (step_nxt.stop) begin
                  run_in = 1'b0;
               end
               // drop the backlog once the cap is hit
               if (steps_inc >= {1'b0, cap}) begin
                  accum_in = '0;
                  state_in = fbseq_pkg::SEQ_DONE;
               end else if (step_nxt.stop) begin
                  state_in = fbseq_pkg::SEQ_DONE;
               end
            end else begin
               state_in = fbseq_pkg::SEQ_DONE;
            end
         end
         fbseq_pkg::SEQ_DONE: begin
            if (load_rsp) begin
               state_in = fbseq_pkg::SEQ_IDLE;
            end
         end
         default: state_in = fbseq_pkg::SEQ_IDLE;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_pos_in    = rsp_pos_ff;
      rsp_run_in    = rsp_run_ff;
      rsp_bounce_in = rsp_bounce_ff;
      rsp_steps_in  = rsp_steps_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_pos_in    = pos_ff;
         rsp_run_in    = run_ff;
         rsp_bounce_in = bounce_ff;
         rsp_steps_in  = steps_ff;
      end
   end

   // control and play state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbseq_pkg::SEQ_IDLE;
         pos_ff       <= '0;
         accum_ff     <= '0;
         bounce_ff    <= 1'b0;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         accum_ff     <= accum_in;
         bounce_ff    <= bounce_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      steps_ff      <= steps_in;
      elapsed_ff    <= elapsed_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_bounce_ff <= rsp_bounce_in;
      rsp_steps_ff  <= rsp_steps_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_index = rsp_pos_ff;
   assign rsp_playing     = rsp_run_ff;
   assign rsp_reversing   = rsp_bounce_ff;
   assign rsp_steps_taken = rsp_steps_ff;

`include "flipbook_frame_sequencer_core_assert.svh"

   `FBSEQ_ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != fbseq_pkg::SEQ_IDLE)
   `FBSEQ_ASSERT_NEXT(a_add_then_step, clock, reset, state_ff == fbseq_pkg::SEQ_ADD, state_ff == fbseq_pkg::SEQ_STEP)
   `FBSEQ_ASSERT_NOW(a_step_below_cap, clock, reset, state_ff == fbseq_pkg::SEQ_STEP, steps_ff < cap)
   `FBSEQ_ASSERT_NEXT(a_done_delivers, clock, reset, (state_ff == fbseq_pkg::SEQ_DONE) && !rsp_valid_ff, rsp_valid_ff && (state_ff == fbseq_pkg::SEQ_IDLE))

endmodule
`default_nettype wire

/* rtl/flipbook_frame_sequencer_core.sv */
// Top level of the flipbook frame sequencer: register file and sequencer
//
// Usage:
//  - Request channel (req_valid/req_stall, req_op, req_elapsed): op 0 begins
//    playback, op 1 advances the play position by req_elapsed time units.
//  - Response channel (rsp_valid/rsp_stall): one transaction per request with
//    frame index, playing and reversing flags and the number of steps taken.
//  - Registers (play style, invert, frame count, frame period) are written
//    through the APB-style port while no request is in flight; pready is tied high.
//  - A begin skips the step loop. An advance accumulates req_elapsed, then runs
//    a one-step-per-cycle subtract-and-step loop that shares a single 32-bit
//    adder with the accumulate step; the loop stops at the step cap (effective
//    frame count + 1) or at the end of a play-once run.
//  - One request is processed at a time; req_stall is high from acceptance
//    until the result is loaded into the response register.
//  - A waiting response does not block the next request; if the response
//    register is still full, the finished result waits until it is taken.
//  - Reset clears the registers, the play state (not playing, frame 0) and
//    any pending response.
`default_nettype none
module flipbook_frame_sequencer_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_op,
   input  wire logic [fbseq_pkg::TIME_W-1:0]  req_elapsed,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [fbseq_pkg::POS_W-1:0]   rsp_frame_index,
   output logic                               rsp_playing,
   output logic                               rsp_reversing,
   output logic      [fbseq_pkg::CNT_W-1:0]   rsp_steps_taken,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [fbseq_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [fbseq_pkg::DATA_W-1:0]  pwdata,
   output logic      [fbseq_pkg::DATA_W-1:0]  prdata,
   output logic                               pready
);

   fbseq_pkg::cfg_type cfg;

   // configuration registers
   fbseq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // play sequencer
   fbseq_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_elapsed     (req_elapsed),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_index (rsp_frame_index),
      .rsp_playing     (rsp_playing),
      .rsp_reversing   (rsp_reversing),
      .rsp_steps_taken (rsp_steps_taken)
   );

endmodule
`default_nettype wire

/* bench/fbseq_frame_checker.sv */
// Frame report checker: tracks register writes, predicts and compares each frame report
module fbseq_frame_checker
   import fbseq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic              req_op,
   input  wire logic [TIME_W-1:0] req_elapsed,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [POS_W-1:0]  rsp_frame_index,
   input  wire logic              rsp_playing,
   input  wire logic              rsp_reversing,
   input  wire logic [CNT_W-1:0]  rsp_steps_taken,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic              pready,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output int                     fail_count,
   output int                     reports_due,
   output int                     reports_checked
);

   typedef struct packed {
      logic [POS_W-1:0] frame;
      logic             playing;
      logic             reversing;
      logic [CNT_W-1:0] steps;
   } frame_report_type;

   // shadow copies of the registers
   logic [1:0]        cfg_style;
   logic              cfg_invert;
   logic [CNT_W-1:0]  cfg_count;
   logic [TIME_W-1:0] cfg_period;

   // predicted play state
   logic [POS_W-1:0]  cur_frame;
   logic [ACC_W-1:0]  time_bank;
   logic              bouncing;
   logic              running;

   frame_report_type  reports_pending[$];
   int                mismatches;

   // Work out the report for one transaction and move the play state on
   function automatic frame_report_type next_frame_report(input logic op,
                                                          input logic [TIME_W-1:0] elapsed);
      int               n;
      int               steps;
      int               step_cap;
      int               fwd;
      int               idx;
      int               last;
      int               dir;
      int               nx;
      logic [ACC_W:0]   sum;
      frame_report_type rep;
      n = (cfg_count > MAX_FRAMES) ? MAX_FRAMES : int'(cfg_count);
      steps = 0;
      if (op == OP_BEGIN) begin
         cur_frame = (cfg_invert && n > 0) ? POS_W'(n - 1) : '0;
         time_bank = '0;
         bouncing  = 1'b0;
         running   = 1'b1;
      end else if (running && n > 1 && cfg_period != '0) begin
         step_cap = n + 1;
         // saturate the accumulator rather than wrap
         sum = {1'b0, time_bank} + (ACC_W + 1)'(elapsed);
         time_bank = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
         fwd = cfg_invert ? -1 : 1;
         while (time_bank >= ACC_W'(cfg_period) && steps < step_cap) begin
            time_bank = time_bank - ACC_W'(cfg_period);
            steps++;
            idx = int'(cur_frame);
            case (cfg_style)
               STYLE_LOOP: begin
                  idx = idx + fwd;
                  if (idx < 0) idx = n - 1;
                  else if (idx >= n) idx = 0;
               end
               STYLE_ONCE: begin
                  last = cfg_invert ? 0 : n - 1;
                  if (idx != last) begin
                     idx = idx + fwd;
                     if (idx < 0) idx = 0;
                     else if (idx >= n) idx = n - 1;
                  end
                  if (idx == last) running = 1'b0;
               end
               STYLE_PINGPONG: begin
                  dir = bouncing ? -fwd : fwd;
                  nx  = idx + dir;
                  // bounce off either end
                  if (nx < 0 || nx >= n) begin
                     bouncing = ~bouncing;
                     dir = -dir;
                     nx  = idx + dir;
                     if (nx < 0) nx = 0;
                     else if (nx >= n) nx = n - 1;
                  end
                  idx = nx;
               end
               default: ;
            endcase
            // keep the index inside the sequence
            if (idx > n - 1) idx = n - 1;
            if (idx < 0) idx = 0;
            cur_frame = POS_W'(idx);
            if (!running) break;
         end
         // drop the backlog once the step cap is hit
         if (steps >= step_cap) time_bank = '0;
      end
      rep.frame     = cur_frame;
      rep.playing   = running;
      rep.reversing = bouncing;
      rep.steps     = CNT_W'(steps);
      return rep;
   endfunction

   always @(posedge clock) begin : watch_channels
      frame_report_type seen;
      frame_report_type due;
      if (reset) begin
         cfg_style  = STYLE_LOOP;
         cfg_invert = 1'b0;
         cfg_count  = '0;
         cfg_period = '0;
         cur_frame  = '0;
         time_bank  = '0;
         bouncing   = 1'b0;
         running    = 1'b0;
         mismatches = 0;
         reports_pending.delete();
         fail_count      <= 0;
         reports_due     <= 0;
         reports_checked <= 0;
      end else begin
         // mirror register writes
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
               REG_STYLE:  cfg_style  = pwdata[1:0];
               REG_INVERT: cfg_invert = pwdata[0];
               REG_COUNT:  cfg_count  = pwdata[CNT_W-1:0];
               REG_PERIOD: cfg_period = pwdata[TIME_W-1:0];
               default: ;
            endcase
         end
         // predict each accepted request
         if (req_valid && !req_stall)
            reports_pending.push_back(next_frame_report(req_op, req_elapsed));
         // compare each delivered report with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            seen.frame     = rsp_frame_index;
            seen.playing   = rsp_playing;
            seen.reversing = rsp_reversing;
            seen.steps     = rsp_steps_taken;
            if (reports_pending.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: report with no request outstanding: frame %0d playing %0b",
                           $time, seen.frame, seen.playing);
            end else begin
               due = reports_pending.pop_front();
               if (seen.frame !== due.frame || seen.playing !== due.playing ||
                   seen.reversing !== due.reversing || seen.steps !== due.steps) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: report mismatch: expected frame %0d playing %0b reversing %0b steps %0d",
                              $time, due.frame, due.playing, due.reversing, due.steps);
                     $display("%0t:                  got frame %0d playing %0b reversing %0b steps %0d",
                              $time, seen.frame, seen.playing, seen.reversing, seen.steps);
                  end
               end
               reports_checked <= reports_checked + 1;
            end
         end
         // outstanding predictions count against the run once it has ended
         reports_due <= reports_pending.size();
         fail_count  <= mismatches + reports_pending.size();
      end
   end

endmodule

/* bench/flipbook_frame_sequencer_core_tb.sv */
// Testbench top for the flipbook frame sequencer: stimulus, register setup and verdict
module flipbook_frame_sequencer_core_tb;
   import fbseq_pkg::*;

   localparam logic [1:0] STYLE_UNUSED = 2'd3;
   localparam int QUIET_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_PHASES = 30;
   localparam int PHASE_ITEMS   = 61;
   localparam int SETTLE_CYCLES = 300;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_op = OP_BEGIN;
   logic [TIME_W-1:0] req_elapsed = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [POS_W-1:0]  rsp_frame_index;
   logic              rsp_playing;
   logic              rsp_reversing;
   logic [CNT_W-1:0]  rsp_steps_taken;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   int fail_count;
   int reports_due;
   int reports_checked;
   int stall_pct = 0;
   int hold_requests = 0;
   int holds_served;
   int hold_left;
   int quiet_cycles;
   int send_idle_pct = 0;
   int begins_sent = 0;
   int advances_sent = 0;
   int settings_applied = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   flipbook_frame_sequencer_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_elapsed     (req_elapsed),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_index (rsp_frame_index),
      .rsp_playing     (rsp_playing),
      .rsp_reversing   (rsp_reversing),
      .rsp_steps_taken (rsp_steps_taken),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   fbseq_frame_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_elapsed     (req_elapsed),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_index (rsp_frame_index),
      .rsp_playing     (rsp_playing),
      .rsp_reversing   (rsp_reversing),
      .rsp_steps_taken (rsp_steps_taken),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .fail_count      (fail_count),
      .reports_due     (reports_due),
      .reports_checked (reports_checked)
   );

   // Response side: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         holds_served <= 0;
         hold_left    <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= (int'($urandom_range(99)) < stall_pct);
      end
   end

   // Abort if no transaction moves for too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One register write: setup cycle, then access cycle until pready
   task automatic write_register(input logic [1:0] index, input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   // Hold the sender until every outstanding report has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_due != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [1:0] style, input logic invert,
                                 input logic [CNT_W-1:0] count,
                                 input logic [TIME_W-1:0] period);
      drain_results();
      write_register(REG_STYLE, DATA_W'(style));
      write_register(REG_INVERT, DATA_W'(invert));
      write_register(REG_COUNT, DATA_W'(count));
      write_register(REG_PERIOD, DATA_W'(period));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      settings_applied++;
   endtask

   // Offer one transaction and wait for it to be taken; idle now and then
   task automatic send_item(input logic op, input logic [TIME_W-1:0] elapsed);
      req_valid   <= 1'b1;
      req_op      <= op;
      req_elapsed <= elapsed;
      do @(posedge clock); while (req_stall);
      if (op == OP_BEGIN) begins_sent++;
      else advances_sent++;
      if (send_idle_pct != 0 && int'($urandom_range(99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   initial begin
      logic [1:0]        style;
      logic              invert;
      logic [CNT_W-1:0]  count;
      logic [TIME_W-1:0] period;
      logic              op;
      logic [TIME_W-1:0] elapsed;
      int unsigned       pick;
      int unsigned       span;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // loop: advance before any begin, sub-period, exact period, several steps, step cap
      apply_settings(STYLE_LOOP, 1'b0, 9'd4, 24'd10);
      send_item(OP_ADVANCE, 24'd5);
      send_item(OP_BEGIN, 24'hFFFFFF);
      send_item(OP_ADVANCE, 24'd0);
      send_item(OP_ADVANCE, 24'd9);
      send_item(OP_ADVANCE, 24'd1);
      send_item(OP_ADVANCE, 24'd35);
      send_item(OP_ADVANCE, 24'hFFFFFF);

      // play once, inverted: runs down to frame zero and stops
      apply_settings(STYLE_ONCE, 1'b1, 9'd5, 24'd1);
      send_item(OP_BEGIN, 24'd0);
      send_item(OP_ADVANCE, 24'd3);
      send_item(OP_ADVANCE, 24'd100);
      send_item(OP_ADVANCE, 24'd5);

      // ping-pong: bounce off both ends
      apply_settings(STYLE_PINGPONG, 1'b0, 9'd3, 24'd7);
      send_item(OP_BEGIN, 24'd0);
      send_item(OP_ADVANCE, 24'd49);
      send_item(OP_ADVANCE, 24'hFFFFFF);

      // unused style, saturated frame count, largest period
      apply_settings(STYLE_UNUSED, 1'b1, 9'd300, 24'hFFFFFF);
      send_item(OP_BEGIN, 24'd0);
      send_item(OP_ADVANCE, 24'hFFFFFF);
      send_item(OP_ADVANCE, 24'hFFFFFE);

      // zero and one frame, zero period: begin plays but advance does nothing
      apply_settings(STYLE_LOOP, 1'b1, 9'd0, 24'd1);
      send_item(OP_BEGIN, 24'd0);
      send_item(OP_ADVANCE, 24'd10);
      apply_settings(STYLE_PINGPONG, 1'b1, 9'd1, 24'd1);
      send_item(OP_BEGIN, 24'd0);
      send_item(OP_ADVANCE, 24'd10);
      apply_settings(STYLE_LOOP, 1'b0, 9'd256, 24'd0);
      send_item(OP_BEGIN, 24'd0);
      send_item(OP_ADVANCE, 24'hFFFFFF);

      // widest count field with the smallest period: full step cap
      apply_settings(STYLE_LOOP, 1'b0, 9'd511, 24'd1);
      send_item(OP_BEGIN, 24'd0);
      send_item(OP_ADVANCE, 24'hFFFFFF);

      // random phases: begin, then mostly advances near the frame period
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         style  = ($urandom_range(9) == 0) ? STYLE_UNUSED : 2'($urandom_range(2));
         invert = 1'($urandom_range(1));
         pick = $urandom_range(99);
         if (pick < 8) count = CNT_W'($urandom_range(1));
         else if (pick < 14) count = CNT_W'(MAX_FRAMES);
         else if (pick < 20) count = CNT_W'($urandom_range(257, 511));
         else count = CNT_W'($urandom_range(2, 20));
         pick = $urandom_range(99);
         if (pick < 5) period = '0;
         else if (pick < 12) period = 24'hFFFFFF - TIME_W'($urandom_range(3));
         else period = TIME_W'($urandom_range(1, 200));
         apply_settings(style, invert, count, period);

         // cycle through the idling modes
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 47; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 47; end
            default: begin send_idle_pct = 25; stall_pct <= 25; end
         endcase

         span = 4 * int'(period);
         if (span > 32'hFFFFFF) span = 32'hFFFFFF;
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            pick = $urandom_range(99);
            if (item == 0 || pick < ((style == STYLE_ONCE) ? 20 : 6)) op = OP_BEGIN;
            else op = OP_ADVANCE;
            pick = $urandom_range(99);
            if (pick < 65) elapsed = TIME_W'($urandom_range(0, span));
            else if (pick < 85) elapsed = TIME_W'($urandom);
            else if (pick < 92) elapsed = '0;
            else elapsed = '1;
            // hold the response side off while requests keep coming
            if (phase == 5 && item == 10) hold_requests <= hold_requests + 1;
            // pause the sender until everything is back
            if (phase == 9 && item == 30) drain_results();
            send_item(op, elapsed);
         end
      end

      drain_results();
      send_idle_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d begin and %0d advance transactions over %0d register settings;",
               begins_sent, advances_sent, settings_applied);
      $display("%0d frame reports checked across all styles, directions and idling modes.",
               reports_checked);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/fbseq_pkg.sv
rtl/fbseq_csr.sv
rtl/fbseq_step.sv
rtl/fbseq_seq.sv
rtl/flipbook_frame_sequencer_core.sv
bench/fbseq_frame_checker.sv
bench/flipbook_frame_sequencer_core_tb.sv
